@@ hdl/jsu_pkg.sv @@
// shared types and constants for the json string unescaper
`default_nettype none
package jsu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       bad_escape;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	// what the front end hands to the back end for one input byte
	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_CODE,
		CMD_ERR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] code;
		logic        last;
	} cmd_t;

	localparam logic [7:0] BACKSLASH   = 8'h5C;
	localparam logic [7:0] LETTER_U    = 8'h75;
	localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
	localparam logic [7:0] UTF8_CONT   = 8'h80;
	localparam logic [3:0] HEX_LETTER0 = 4'hA;

endpackage
`default_nettype wire

@@ hdl/json_string_unescape_utf8_unit.sv @@
// top level of the json string unescaper with utf-8 output
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_item   (in_item_t: byte, last flag)
// out       output     out_valid / out_ready out_item  (out_item_t: byte, error, ends)
//
// one input transaction per cycle while the command queue has room
// a \uXXXX escape gives 1 to 3 transactions from the back end, one per unstalled cycle
// sustained output is one byte per cycle while out_ready is high; the queue of
// FifoDepth commands absorbs the multi-byte bursts so the input side keeps streaming
// reset (arst_n low) clears escape state, the drop flag, queue pointers and out_valid
// in_ready depends only on queue fullness, never on out_ready directly
`default_nettype none
module json_string_unescape_utf8_unit
	import jsu_pkg::*;
#(
	parameter int FifoDepth = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_item,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_item
);

	// front to queue
	logic accept;
	logic push;
	cmd_t push_cmd;

	// queue to back
	cmd_t head;
	logic empty;
	logic full;
	logic pop;

	// every accepted byte pushes at most one command, so a free slot is enough
	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (in_item),
		.push     (push),
		.push_cmd (push_cmd)
	);

	jsu_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	// back end drains one output byte per cycle into its output register unless stalled
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
`default_nettype wire

@@ hdl/jsu_front.sv @@
// front end: escape state machine that classifies each input byte
`default_nettype none
module jsu_front
	import jsu_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     accept,
	input  wire in_item_t item,
	output logic          push,
	output cmd_t          push_cmd
);

	typedef enum logic [2:0] {
		PH_TEXT,
		PH_BSL,
		PH_HEX1,
		PH_HEX2,
		PH_HEX3,
		PH_HEX4
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [11:0] accum_q, accum_d;
	logic        drop_q, drop_d;
	logic [3:0]  digit;
	logic        digit_ok;
	logic        fail;
	logic [7:0]  b;
	logic        last;

	assign b    = item.in_byte;
	assign last = item.string_last;

	always_comb begin
		digit    = 4'd0;
		digit_ok = 1'b1;
		case (b) inside
			[8'h30:8'h39]: digit = b[3:0];
			[8'h61:8'h66]: digit = b[3:0] - 4'd1 + HEX_LETTER0;
			[8'h41:8'h46]: digit = b[3:0] - 4'd1 + HEX_LETTER0;
			default:       digit_ok = 1'b0;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		accum_d  = accum_q;
		drop_d   = drop_q;
		push     = 1'b0;
		fail     = 1'b0;
		push_cmd = '{kind: CMD_BYTE, code: {8'd0, b}, last: last};
		if (accept) begin
			if (drop_q) begin
				if (last) begin
					drop_d  = 1'b0;
					phase_d = PH_TEXT;
					accum_d = '0;
				end
			end else begin
				case (phase_q)
					PH_BSL: begin
						if (b == LETTER_U) begin
							if (last) begin
								fail = 1'b1;
							end else begin
								phase_d = PH_HEX1;
								accum_d = '0;
							end
						end else begin
							phase_d = PH_TEXT;
							push    = 1'b1;
						end
					end
					PH_HEX1, PH_HEX2, PH_HEX3: begin
						if (!digit_ok || last) begin
							fail = 1'b1;
						end else begin
							accum_d = {accum_q[7:0], digit};
							phase_d = phase_t'(phase_q + 3'd1);
						end
					end
					PH_HEX4: begin
						if (!digit_ok) begin
							fail = 1'b1;
						end else begin
							push          = 1'b1;
							push_cmd.kind = CMD_CODE;
							push_cmd.code = {accum_q, digit};
							phase_d       = PH_TEXT;
							accum_d       = '0;
						end
					end
					default: begin
						phase_d = PH_TEXT;
						if (b == BACKSLASH) begin
							if (last) begin
								fail = 1'b1;
							end else begin
								phase_d = PH_BSL;
							end
						end else begin
							push = 1'b1;
						end
					end
				endcase
				// an error result always closes the string
				if (fail) begin
					push          = 1'b1;
					push_cmd.kind = CMD_ERR;
					push_cmd.code = '0;
					push_cmd.last = 1'b1;
					phase_d       = PH_TEXT;
					accum_d       = '0;
					drop_d        = !last;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			accum_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			drop_q  <= drop_d;
		end
	end

endmodule
`default_nettype wire

@@ hdl/jsu_fifo.sv @@
// command queue between the front and back ends
`default_nettype none
module jsu_fifo
	import jsu_pkg::*;
#(
	parameter int Depth = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	cmd_t          mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(Depth));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/jsu_back.sv @@
// back end: expands commands into output bytes through an output register
`default_nettype none
module jsu_back
	import jsu_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic empty,
	output logic      pop,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_item_t out_item
);

	logic [1:0]  idx_q;
	logic [1:0]  nbytes;
	logic        load;
	logic        is_final;
	logic [15:0] c;
	logic [7:0]  byte_d;
	logic        out_valid_q;
	out_item_t   out_q;

	assign c = head.code;

	always_comb begin
		nbytes = 2'd1;
		if (head.kind == CMD_CODE) begin
			if (c[15:7] == '0) begin
				nbytes = 2'd1;
			end else if (c[15:11] == '0) begin
				nbytes = 2'd2;
			end else begin
				nbytes = 2'd3;
			end
		end
	end

	always_comb begin
		byte_d = 8'd0;
		case (head.kind)
			CMD_BYTE: byte_d = c[7:0];
			CMD_CODE: begin
				if (nbytes == 2'd1) begin
					byte_d = c[7:0];
				end else if (nbytes == 2'd2) begin
					byte_d = (idx_q == 2'd0) ? (UTF8_LEAD2 | {3'd0, c[10:6]})
						: (UTF8_CONT | {2'd0, c[5:0]});
				end else begin
					case (idx_q)
						2'd0:    byte_d = UTF8_LEAD3 | {4'd0, c[15:12]};
						2'd1:    byte_d = UTF8_CONT | {2'd0, c[11:6]};
						default: byte_d = UTF8_CONT | {2'd0, c[5:0]};
					endcase
				end
			end
			default: byte_d = 8'd0;
		endcase
	end

	assign load     = !empty && (!out_valid_q || out_ready);
	assign is_final = (idx_q == nbytes - 2'd1);
	assign pop      = load && is_final;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte   <= byte_d;
			out_q.bad_escape <= (head.kind == CMD_ERR);
			out_q.run_last   <= is_final;
			out_q.string_end <= is_final && head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_final ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_mid_code_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !empty && head.kind == CMD_CODE)
		else $error("byte index advanced without a multi-byte command");
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.bad_escape |->
			out_q.out_byte == 8'd0 && out_q.run_last && out_q.string_end)
		else $error("error result not a single end-of-string zero byte");
	a_end_on_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.string_end |-> out_q.run_last)
		else $error("string end flagged inside a multi-byte run");
	a_pop_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> load && idx_q == nbytes - 2'd1)
		else $error("command popped before its last byte");
`endif

endmodule
`default_nettype wire
